@@ rtl/msbp_pkg.sv @@
// ----------------------------------------------------------------------------
// msbp_pkg
// Shared types and constants for the MSB-first bit packer.
// ----------------------------------------------------------------------------
package msbp_pkg;

    // Limits and widths of the packer.
    localparam int MAX_WORDS   = 1024;
    localparam int CAP_W       = 11;
    localparam int CAP_RESET   = 256;
    localparam int WORD_W      = 32;
    localparam int WIDTH_W     = 6;
    localparam int ADDR_W      = 10;
    localparam int TOTAL_W     = 16;
    localparam int QUEUE_DEPTH = 2;

    // Action codes as they arrive on the input channel.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_ALIGN = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_START = 2'd3;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUT,
        OP_ALIGN,
        OP_FLUSH,
        OP_START
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [WORD_W-1:0]  value;
        logic [WIDTH_W-1:0] width;
    } op_item_t;

    typedef struct packed {
        logic               word_valid;
        logic [WORD_W-1:0]  word_data;
        logic [ADDR_W-1:0]  word_addr;
        logic               overflow;
        logic [TOTAL_W-1:0] bits_used;
    } result_t;

endpackage

@@ rtl/msbp_in_if.sv @@
// ----------------------------------------------------------------------------
// msbp_in_if
// Input channel of the bit packer: one action item per handshake.
// ----------------------------------------------------------------------------
interface msbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] field_value;
    logic [5:0]  field_width;

    modport source (output valid, output action, output field_value, output field_width,
                    input ready);
    modport sink   (input valid, input action, input field_value, input field_width,
                    output ready);
endinterface

@@ rtl/msbp_out_if.sv @@
// ----------------------------------------------------------------------------
// msbp_out_if
// Output channel of the bit packer: one result item per handshake.
// ----------------------------------------------------------------------------
interface msbp_out_if;
    logic        valid;
    logic        ready;
    logic        word_valid;
    logic [31:0] word_data;
    logic [9:0]  word_addr;
    logic        overflow;
    logic [15:0] bits_used;

    modport source (output valid, output word_valid, output word_data, output word_addr,
                    output overflow, output bits_used, input ready);
    modport sink   (input valid, input word_valid, input word_data, input word_addr,
                    input overflow, input bits_used, output ready);
endinterface

@@ rtl/msbp_front.sv @@
// ----------------------------------------------------------------------------
// msbp_front
// Accepts input items, clamps the field width, masks the field value and
// classifies each item into an operation for the queue.
// ----------------------------------------------------------------------------
module msbp_front
    import msbp_pkg::*;
(
    msbp_in_if.sink  in_item,
    input  logic     q_full,
    output logic     q_push,
    output op_item_t q_item
);

    logic [WIDTH_W-1:0] width_clamped;
    logic [WORD_W-1:0]  value_mask;

    assign in_item.ready = !q_full;
    assign q_push        = in_item.valid && !q_full;

    // Widths above 32 behave as 32.
    assign width_clamped = (in_item.field_width > WIDTH_W'(WORD_W)) ? WIDTH_W'(WORD_W)
                                                                    : in_item.field_width;
    assign value_mask    = {WORD_W{1'b1}} >> (WIDTH_W'(WORD_W) - width_clamped);

    always_comb
    begin
        q_item.value = in_item.field_value & value_mask;
        q_item.width = width_clamped;
        unique case (in_item.action)
            ACT_WRITE: q_item.op = (width_clamped == '0) ? OP_NONE : OP_PUT;
            ACT_ALIGN: q_item.op = OP_ALIGN;
            ACT_FLUSH: q_item.op = OP_FLUSH;
            ACT_START: q_item.op = OP_START;
            default:   q_item.op = OP_NONE;
        endcase
    end

endmodule

@@ rtl/msbp_fifo.sv @@
// ----------------------------------------------------------------------------
// msbp_fifo
// Short queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module msbp_fifo
    import msbp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  op_item_t push_item,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output op_item_t head_item
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    op_item_t         mem [DEPTH];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/msbp_back.sv @@
// ----------------------------------------------------------------------------
// msbp_back
// Carries out queued operations on the packing state and holds the result
// item in an output register.
// ----------------------------------------------------------------------------
module msbp_back
    import msbp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] capacity,
    input  logic             q_valid,
    input  op_item_t         q_item,
    output logic             q_pop,
    output logic             res_valid,
    input  logic             res_ready,
    output result_t          res
);

    localparam logic [CAP_W-1:0] MAX_CAP = CAP_W'(MAX_WORDS);

    logic [WORD_W-1:0]  part_reg, part_next;
    logic [4:0]         bit_pos_reg, bit_pos_next;
    logic [CAP_W-1:0]   word_pos_reg, word_pos_next;
    logic [TOTAL_W-1:0] bit_total_reg, bit_total_next;
    logic               overflow_reg, overflow_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic [CAP_W-1:0]   eff_words;
    logic [TOTAL_W-1:0] cap_bits;
    logic               do_put;
    logic [WIDTH_W-1:0] put_width;
    logic [WORD_W-1:0]  put_value;
    logic [TOTAL_W:0]   total_sum;
    logic               fits;
    logic [6:0]         pos_sum;
    logic [95:0]        placed_wide;
    logic [63:0]        merged;
    logic               room;
    logic               emit;
    logic [WORD_W-1:0]  emit_data;

    // Capacity below one acts as one, above the limit as the limit.
    always_comb
    begin
        if (capacity == '0)
        begin
            eff_words = CAP_W'(1);
        end
        else if (capacity > MAX_CAP)
        begin
            eff_words = MAX_CAP;
        end
        else
        begin
            eff_words = capacity;
        end
    end

    assign cap_bits = TOTAL_W'({eff_words, 5'b0});
    assign room     = (word_pos_reg < eff_words);

    assign do_put    = (q_item.op == OP_PUT) ||
                       ((q_item.op == OP_ALIGN) && (bit_total_reg[2:0] != 3'b0));
    assign put_width = (q_item.op == OP_ALIGN) ? (WIDTH_W'(8) - {3'b0, bit_total_reg[2:0]})
                                               : q_item.width;
    assign put_value = (q_item.op == OP_ALIGN) ? '0 : q_item.value;

    assign total_sum   = {1'b0, bit_total_reg} + (TOTAL_W + 1)'(put_width);
    assign fits        = (total_sum <= {1'b0, cap_bits});
    assign pos_sum     = {2'b0, bit_pos_reg} + {1'b0, put_width};
    // The field lands with its last bit at bit position 64 - pos_sum.
    assign placed_wide = {put_value, 64'b0} >> pos_sum;
    assign merged      = {part_reg, 32'b0} | placed_wide[63:0];

    assign q_pop = q_valid && (!out_valid_reg || res_ready);

    always_comb
    begin
        part_next      = part_reg;
        bit_pos_next   = bit_pos_reg;
        word_pos_next  = word_pos_reg;
        bit_total_next = bit_total_reg;
        overflow_next  = overflow_reg;
        emit           = 1'b0;
        emit_data      = '0;

        if (q_pop)
        begin
            unique case (q_item.op)
                OP_NONE:
                begin
                end
                OP_PUT, OP_ALIGN:
                begin
                    if (do_put)
                    begin
                        if (!fits)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            bit_total_next = total_sum[TOTAL_W-1:0];
                            bit_pos_next   = pos_sum[4:0];
                            if (pos_sum[5])
                            begin
                                part_next = merged[31:0];
                                if (room)
                                begin
                                    emit          = 1'b1;
                                    emit_data     = merged[63:32];
                                    word_pos_next = word_pos_reg + 1'b1;
                                end
                                else
                                begin
                                    overflow_next = 1'b1;
                                end
                            end
                            else
                            begin
                                part_next = merged[63:32];
                            end
                        end
                    end
                end
                OP_FLUSH:
                begin
                    if (bit_pos_reg != '0)
                    begin
                        if (!room)
                        begin
                            overflow_next = 1'b1;
                        end
                        else
                        begin
                            emit          = 1'b1;
                            emit_data     = part_reg;
                            word_pos_next = word_pos_reg + 1'b1;
                        end
                    end
                end
                OP_START:
                begin
                    part_next      = '0;
                    bit_pos_next   = '0;
                    word_pos_next  = '0;
                    bit_total_next = '0;
                    overflow_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        out_next.word_valid = emit;
        out_next.word_data  = emit_data;
        out_next.word_addr  = emit ? word_pos_reg[ADDR_W-1:0] : '0;
        out_next.overflow   = overflow_next;
        out_next.bits_used  = bit_total_next;

        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg      <= '0;
            bit_pos_reg   <= '0;
            word_pos_reg  <= '0;
            bit_total_reg <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            part_reg      <= part_next;
            bit_pos_reg   <= bit_pos_next;
            word_pos_reg  <= word_pos_next;
            bit_total_reg <= bit_total_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg <= out_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ rtl/msb_first_bit_packer_core.sv @@
// ----------------------------------------------------------------------------
// msb_first_bit_packer_core
// Packs fields of 1 to 32 bits, most significant bit first, into indexed
// 32-bit words, with align, flush and start actions and a sticky overflow.
// ----------------------------------------------------------------------------
//
// Channel     Direction  Handshake     Contents
// ---------   ---------  ------------  ------------------------------------------
// in_item     sink       valid/ready   action, field_value, field_width
// out_item    source     valid/ready   word_valid, word_data, word_addr,
//                                      overflow, bits_used
// cfg         write      cfg_wr_en     cfg_wr_data = capacity_words (11 bits)
//
// One item is accepted every clock cycle for as long as the output side keeps
// taking results. Its result appears on out_item after a pass through the
// two-entry operation queue and the packing stage, whose registered update of
// the partial word sets that rate. Reset clears the packing state and the
// queue, and sets the capacity to 256 words. When out_item stalls, the result
// register holds and the queue absorbs up to two more items before
// in_item.ready falls.
//
module msb_first_bit_packer_core
    import msbp_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    msbp_in_if.sink          in_item,
    msbp_out_if.source       out_item
);

    // Configured buffer size in words; clamping happens in the back end.
    logic [CAP_W-1:0] capacity_reg;

    // Front end to queue.
    logic     q_push;
    logic     q_full;
    op_item_t q_push_item;

    // Queue to back end.
    logic     q_pop;
    logic     q_not_empty;
    op_item_t q_head_item;

    // Result register contents.
    logic    res_valid;
    result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    // The front end decodes the action and prepares the field for packing.
    msbp_front u_front (
        .in_item (in_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    // The queue lets the front end keep accepting while the result waits.
    msbp_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    // The back end owns the partial word, positions, bit count and flag.
    msbp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity_reg),
        .q_valid   (q_not_empty),
        .q_item    (q_head_item),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_ready (out_item.ready),
        .res       (res)
    );

    assign out_item.valid      = res_valid;
    assign out_item.word_valid = res.word_valid;
    assign out_item.word_data  = res.word_data;
    assign out_item.word_addr  = res.word_addr;
    assign out_item.overflow   = res.overflow;
    assign out_item.bits_used  = res.bits_used;

endmodule

@@ rtl/msbp_checker.sv @@
// ----------------------------------------------------------------------------
// msbp_checker
// Port-level checks on the bit packer's result channel, bound to the top.
// ----------------------------------------------------------------------------
module msbp_checker
    import msbp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic               word_valid,
    input logic [WORD_W-1:0]  word_data,
    input logic [ADDR_W-1:0]  word_addr,
    input logic [TOTAL_W-1:0] bits_used
);

    // A stalled result keeps its contents.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(word_data) && $stable(word_addr)
            && $stable(bits_used))
        else $error("result changed while stalled");

    // Without a word the data and address read as zero.
    a_idle_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !word_valid |-> word_data == '0 && word_addr == '0)
        else $error("word fields not zero without a word");

    // A word is only ever produced from bits that were written.
    a_word_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_valid |-> bits_used != '0)
        else $error("word emitted with no bits written");

    // The bit count never passes the largest buffer.
    a_bits_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bits_used <= TOTAL_W'(MAX_WORDS * WORD_W))
        else $error("bit count beyond largest capacity");

endmodule

bind msb_first_bit_packer_core msbp_checker u_msbp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_item.valid),
    .out_ready  (out_item.ready),
    .word_valid (out_item.word_valid),
    .word_data  (out_item.word_data),
    .word_addr  (out_item.word_addr),
    .bits_used  (out_item.bits_used)
);
